// ----- src/nlb_pkg.sv -----
// Shared types and constants for the NV12 letterbox to RGB unit.
`timescale 1ns / 1ps
package nlb_pkg;

  // Widths of sizes, store addresses and divider operands.
  localparam int SZ_W   = 10;
  localparam int ADDR_W = 21;
  localparam int DVD_W  = 21;
  localparam int DVS_W  = 11;
  localparam int CMDQ_DEPTH = 4;

  // BT.601 integer coefficients and the letterbox gray level.
  localparam logic signed [10:0] K_298 = 11'sd298;
  localparam logic signed [10:0] K_409 = 11'sd409;
  localparam logic signed [10:0] K_100 = 11'sd100;
  localparam logic signed [10:0] K_208 = 11'sd208;
  localparam logic signed [10:0] K_516 = 11'sd516;
  localparam logic signed [19:0] ROUND_BIAS = 20'sd128;
  localparam logic signed [9:0]  LUMA_OFS   = 10'sd16;
  localparam logic signed [9:0]  CHROMA_OFS = 10'sd128;
  localparam logic [7:0] GRAY = 8'd114;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SRC_WIDTH     = 3'd0,
    CFG_SRC_HEIGHT    = 3'd1,
    CFG_TARGET_WIDTH  = 3'd2,
    CFG_TARGET_HEIGHT = 3'd3
  } cfg_reg_e;

  // Input item opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [18:0] byte_address;
    logic [7:0]  byte_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_padding;
    logic       last_of_frame;
    logic       status;
  } out_item_t;

  // Work passed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ERROR = 2'd1,
    CMD_PAD   = 2'd2,
    CMD_PIXEL = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              last;
    logic [ADDR_W-1:0] addr_y;
    logic [ADDR_W-1:0] addr_uv;
    logic [7:0]        data;
  } cmd_t;

endpackage

// ----- src/nv12_letterbox_to_rgb_unit.sv -----
// NV12 letterbox to RGB converter, top level.
// The input takes a new transaction only once the front end is through with the last one.
// Image pixels take two passes of the shared radix-2 divider, and the first pixel of a frame
// adds one more pass for the scaled size. Results are registered after acceptance; the 4-entry
// queue or the output can stall them.
// Reset clears control state and sets the sizes to 640, 480, 640, 640; the store is not cleared.
`timescale 1ns / 1ps
module nv12_letterbox_to_rgb_unit #(
  parameter int MAX_SRC_WIDTH     = 640,
  parameter int MAX_SRC_HEIGHT    = 480,
  parameter int MAX_TARGET_WIDTH  = 640,
  parameter int MAX_TARGET_HEIGHT = 640
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  nlb_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output nlb_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i
);
  import nlb_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_in, q_out;

  nlb_front #(
    .MAX_SRC_WIDTH     (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT    (MAX_SRC_HEIGHT),
    .MAX_TARGET_WIDTH  (MAX_TARGET_WIDTH),
    .MAX_TARGET_HEIGHT (MAX_TARGET_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_push_o    (q_push),
    .q_cmd_o     (q_in),
    .q_full_i    (q_full)
  );

  nlb_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_out),
    .empty_o (q_empty)
  );

  nlb_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_out),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ----- src/nlb_div.sv -----
// Radix-2 restoring divider shared by the front end.
`timescale 1ns / 1ps
module nlb_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [nlb_pkg::DVD_W-1:0] dividend_i,
  input  logic [nlb_pkg::DVS_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [nlb_pkg::DVD_W-1:0] quotient_o
);
  import nlb_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W:0]   trial;
  logic             ge;

  // One quotient bit per cycle.
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- src/nlb_front.sv -----
// Front end: configuration, frame check, raster walk and source address generation.
`timescale 1ns / 1ps
module nlb_front #(
  parameter int MAX_SRC_WIDTH     = 640,
  parameter int MAX_SRC_HEIGHT    = 480,
  parameter int MAX_TARGET_WIDTH  = 640,
  parameter int MAX_TARGET_HEIGHT = 640
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  nlb_pkg::in_item_t in_item_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i,
  output logic              q_push_o,
  output nlb_pkg::cmd_t     q_cmd_o,
  input  logic              q_full_i
);
  import nlb_pkg::*;

  localparam longint unsigned STORE_DEPTH =
      longint'(MAX_SRC_WIDTH) * longint'(MAX_SRC_HEIGHT) * 3 / 2;
  localparam logic [18:0] COUNT_MAX = '1;

  typedef enum logic [9:0] {
    F_IDLE  = 10'b0000000001,
    F_ITEM  = 10'b0000000010,
    F_SCALE = 10'b0000000100,
    F_SZDIV = 10'b0000001000,
    F_PIX   = 10'b0000010000,
    F_STX   = 10'b0000100000,
    F_DIVX  = 10'b0001000000,
    F_DIVY  = 10'b0010000000,
    F_ADDR  = 10'b0100000000,
    F_SEND  = 10'b1000000000
  } fstate_e;

  fstate_e state_q, state_d;

  logic [9:0]      src_w_q, tgt_w_q, tgt_h_q;
  logic [8:0]      src_h_q;
  logic [18:0]     count_q;
  logic [SZ_W-1:0] rx_q, ry_q, sw_q, sh_q;
  logic            fit_w_q;

  in_item_t        item_q;
  logic [19:0]     prod_a_q, prod_b_q, mx_q, my_q, ay_q, auv_q, wh_q;
  logic [SZ_W-1:0] sx_q, sy_q;

  logic [SZ_W-1:0] w, h, tw, th;
  logic [19:0]     wh, frame_bytes;
  logic            addr_ok, origin, row_end, frame_end, in_region;
  logic signed [10:0] xdiff, ydiff, xpad, ypad;
  logic signed [11:0] ox, oy;
  logic            div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic            advance;

  // Sizes in use, each clamped to 1..max.
  always_comb begin
    w  = (src_w_q == '0) ? SZ_W'(1) :
         (int'(src_w_q) > MAX_SRC_WIDTH) ? SZ_W'(MAX_SRC_WIDTH) : src_w_q;
    h  = (src_h_q == '0) ? SZ_W'(1) :
         (int'(src_h_q) > MAX_SRC_HEIGHT) ? SZ_W'(MAX_SRC_HEIGHT) : SZ_W'(src_h_q);
    tw = (tgt_w_q == '0) ? SZ_W'(1) :
         (int'(tgt_w_q) > MAX_TARGET_WIDTH) ? SZ_W'(MAX_TARGET_WIDTH) : tgt_w_q;
    th = (tgt_h_q == '0) ? SZ_W'(1) :
         (int'(tgt_h_q) > MAX_TARGET_HEIGHT) ? SZ_W'(MAX_TARGET_HEIGHT) : tgt_h_q;
  end

  // Frame size in bytes and load address check.
  assign wh          = 20'(w) * 20'(h);
  assign frame_bytes = wh + (wh >> 1);
  assign addr_ok     = (20'(item_q.byte_address) < frame_bytes) &&
                       (64'(item_q.byte_address) < STORE_DEPTH);
  assign origin      = (rx_q == '0) && (ry_q == '0);

  // Raster position relative to the centered scaled region.
  assign row_end   = (11'(rx_q) + 11'd1) >= 11'(tw);
  assign frame_end = row_end && ((11'(ry_q) + 11'd1) >= 11'(th));
  assign xdiff     = $signed({1'b0, tw}) - $signed({1'b0, sw_q});
  assign ydiff     = $signed({1'b0, th}) - $signed({1'b0, sh_q});
  assign xpad      = (xdiff + $signed({10'b0, xdiff[10]})) >>> 1;
  assign ypad      = (ydiff + $signed({10'b0, ydiff[10]})) >>> 1;
  assign ox        = $signed({2'b00, rx_q}) - 12'(xpad);
  assign oy        = $signed({2'b00, ry_q}) - 12'(ypad);
  assign in_region = !ox[11] && !oy[11] &&
                     (ox[10:0] < {1'b0, sw_q}) && (oy[10:0] < {1'b0, sh_q});

  nlb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Sequencer for one item at a time.
  always_comb begin
    state_d   = state_q;
    q_push_o  = 1'b0;
    q_cmd_o   = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    advance   = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (push) state_d = F_ITEM;
      end
      F_ITEM: begin
        if (item_q.opcode == OP_LOAD) begin
          q_cmd_o.kind   = CMD_LOAD;
          q_cmd_o.addr_y = ADDR_W'(item_q.byte_address);
          q_cmd_o.data   = item_q.byte_value;
          if (!addr_ok) begin
            state_d = F_IDLE;
          end else if (!q_full_i) begin
            q_push_o = 1'b1;
            state_d  = F_IDLE;
          end
        end else if (origin) begin
          if (20'(count_q) != frame_bytes) begin
            q_cmd_o.kind = CMD_ERROR;
            q_cmd_o.last = 1'b1;
            if (!q_full_i) begin
              q_push_o = 1'b1;
              state_d  = F_IDLE;
            end
          end else begin
            state_d = F_SCALE;
          end
        end else begin
          state_d = F_PIX;
        end
      end
      F_SCALE: begin
        div_start = 1'b1;
        if (prod_a_q <= prod_b_q) begin
          div_dvd = DVD_W'({prod_a_q, 1'b0}) + DVD_W'(w);
          div_dvs = {w, 1'b0};
        end else begin
          div_dvd = DVD_W'({prod_b_q, 1'b0}) + DVD_W'(h);
          div_dvs = {h, 1'b0};
        end
        state_d = F_SZDIV;
      end
      F_SZDIV: begin
        if (div_done) state_d = F_PIX;
      end
      F_PIX: begin
        if (in_region) begin
          state_d = F_STX;
        end else begin
          q_cmd_o.kind = CMD_PAD;
          q_cmd_o.last = frame_end;
          if (!q_full_i) begin
            q_push_o = 1'b1;
            advance  = 1'b1;
            state_d  = F_IDLE;
          end
        end
      end
      F_STX: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(mx_q);
        div_dvs   = DVS_W'(sw_q);
        state_d   = F_DIVX;
      end
      F_DIVX: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(my_q);
          div_dvs   = DVS_W'(sh_q);
          state_d   = F_DIVY;
        end
      end
      F_DIVY: begin
        if (div_done) state_d = F_ADDR;
      end
      F_ADDR: begin
        state_d = F_SEND;
      end
      F_SEND: begin
        q_cmd_o.kind    = CMD_PIXEL;
        q_cmd_o.last    = frame_end;
        q_cmd_o.addr_y  = ADDR_W'(ay_q) + ADDR_W'(sx_q);
        q_cmd_o.addr_uv = ADDR_W'(wh_q) + ADDR_W'(auv_q) + ADDR_W'({sx_q[SZ_W-1:1], 1'b0});
        if (!q_full_i) begin
          q_push_o = 1'b1;
          advance  = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign full        = (state_q != F_IDLE);
  assign cfg_ready_o = 1'b1;

  // Control state: configuration, load count, raster and latched scaled sizes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      src_w_q <= 10'd640;
      src_h_q <= 9'd480;
      tgt_w_q <= 10'd640;
      tgt_h_q <= 10'd640;
      count_q <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
      sw_q    <= '0;
      sh_q    <= '0;
      fit_w_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH:     src_w_q <= cfg_data_i;
          CFG_SRC_HEIGHT:    src_h_q <= cfg_data_i[8:0];
          CFG_TARGET_WIDTH:  tgt_w_q <= cfg_data_i;
          CFG_TARGET_HEIGHT: tgt_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Loads count toward the next frame check, saturating.
      if (state_q == F_ITEM && item_q.opcode == OP_LOAD && state_d == F_IDLE &&
          count_q != COUNT_MAX) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == F_ITEM && item_q.opcode == OP_EMIT && q_push_o) begin
        count_q <= '0;
      end
      // Latch scaled region size at frame start.
      if (state_q == F_SCALE) begin
        fit_w_q <= (prod_a_q <= prod_b_q);
        if (prod_a_q <= prod_b_q) sw_q <= tw;
        else                      sh_q <= th;
      end
      if (state_q == F_SZDIV && div_done) begin
        if (fit_w_q) sh_q <= (div_q == '0) ? SZ_W'(1) : div_q[SZ_W-1:0];
        else         sw_q <= (div_q == '0) ? SZ_W'(1) : div_q[SZ_W-1:0];
      end
      // Step the raster after each emitted pixel.
      if (advance) begin
        if (row_end) begin
          rx_q <= '0;
          if (frame_end) begin
            ry_q    <= '0;
            count_q <= '0;
          end else begin
            ry_q <= ry_q + 1'b1;
          end
        end else begin
          rx_q <= rx_q + 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push) item_q <= in_item_i;
    if (state_q == F_ITEM) begin
      prod_a_q <= 20'(tw) * 20'(h);
      prod_b_q <= 20'(th) * 20'(w);
    end
    if (state_q == F_PIX) begin
      mx_q <= 20'(ox[SZ_W-1:0]) * 20'(w);
      my_q <= 20'(oy[SZ_W-1:0]) * 20'(h);
    end
    if (state_q == F_DIVX && div_done) begin
      sx_q <= (div_q > DVD_W'(w - 1'b1)) ? (w - 1'b1) : div_q[SZ_W-1:0];
    end
    if (state_q == F_DIVY && div_done) begin
      sy_q <= (div_q > DVD_W'(h - 1'b1)) ? (h - 1'b1) : div_q[SZ_W-1:0];
    end
    if (state_q == F_ADDR) begin
      ay_q  <= 20'(sy_q) * 20'(w);
      auv_q <= 20'(sy_q >> 1) * 20'(w);
      wh_q  <= wh;
    end
  end

endmodule

// ----- src/nlb_cmdq.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module nlb_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nlb_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output nlb_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import nlb_pkg::*;

  localparam int PTR_W = $clog2(CMDQ_DEPTH);

  cmd_t             entry_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W + 1)'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_q] <= cmd_i;
  end

endmodule

// ----- src/nlb_back.sv -----
// Back end: frame store, sample fetch, color conversion and result register.
`timescale 1ns / 1ps
module nlb_back #(
  parameter int MAX_SRC_WIDTH  = 640,
  parameter int MAX_SRC_HEIGHT = 480
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nlb_pkg::cmd_t      cmd_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output nlb_pkg::out_item_t out_item_o
);
  import nlb_pkg::*;

  localparam longint unsigned STORE_DEPTH =
      longint'(MAX_SRC_WIDTH) * longint'(MAX_SRC_HEIGHT) * 3 / 2;
  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_RY   = 6'b000010,
    B_RU   = 6'b000100,
    B_RV   = 6'b001000,
    B_MUL  = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;
  logic    out_valid_q, out_free, out_load;
  out_item_t out_q, out_d;

  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rdata_q, rbyte, y_q, u_q;
  logic              oob_q, we;
  logic [ADDR_W-1:0] raddr, py_q, puv_q;
  logic              last_q;

  logic signed [9:0]  c_s, d_s, e_s;
  logic signed [19:0] pc_q, pre_q, pgd_q, pge_q, pbd_q;
  logic signed [19:0] r_sum, g_sum, b_sum;

  function automatic logic [7:0] sat_byte(input logic signed [19:0] acc);
    logic signed [11:0] q;
    begin
      q = $signed(acc[19:8]);
      if (q < 12'sd0)        sat_byte = 8'd0;
      else if (q > 12'sd255) sat_byte = 8'd255;
      else                   sat_byte = q[7:0];
    end
  endfunction

  assign out_free = !out_valid_q || pop;
  assign rbyte    = oob_q ? 8'd0 : rdata_q;

  // Conversion terms.
  assign c_s   = $signed({2'b00, y_q}) - LUMA_OFS;
  assign d_s   = $signed({2'b00, u_q}) - CHROMA_OFS;
  assign e_s   = $signed({2'b00, rbyte}) - CHROMA_OFS;
  assign r_sum = pc_q + pre_q + ROUND_BIAS;
  assign g_sum = pc_q - pgd_q - pge_q + ROUND_BIAS;
  assign b_sum = pc_q + pbd_q + ROUND_BIAS;

  // Read address by fetch step.
  always_comb begin
    case (state_q)
      B_RU:    raddr = puv_q;
      B_RV:    raddr = puv_q + 1'b1;
      default: raddr = py_q;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    we       = 1'b0;
    out_load = 1'b0;
    out_d    = '0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          case (cmd_i.kind)
            CMD_LOAD: begin
              q_pop_o = 1'b1;
              we      = 1'b1;
            end
            CMD_ERROR: begin
              out_d.last_of_frame = 1'b1;
              out_d.status        = 1'b1;
              if (out_free) begin
                q_pop_o  = 1'b1;
                out_load = 1'b1;
              end
            end
            CMD_PAD: begin
              out_d.red           = GRAY;
              out_d.green         = GRAY;
              out_d.blue          = GRAY;
              out_d.is_padding    = 1'b1;
              out_d.last_of_frame = cmd_i.last;
              if (out_free) begin
                q_pop_o  = 1'b1;
                out_load = 1'b1;
              end
            end
            CMD_PIXEL: begin
              q_pop_o = 1'b1;
              state_d = B_RY;
            end
            default: ;
          endcase
        end
      end
      B_RY:  state_d = B_RU;
      B_RU:  state_d = B_RV;
      B_RV:  state_d = B_MUL;
      B_MUL: state_d = B_OUT;
      B_OUT: begin
        out_d.red           = sat_byte(r_sum);
        out_d.green         = sat_byte(g_sum);
        out_d.blue          = sat_byte(b_sum);
        out_d.last_of_frame = last_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)  out_valid_q <= 1'b1;
      else if (pop)  out_valid_q <= 1'b0;
    end
  end

  // Frame store with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem[AW'(cmd_i.addr_y)] <= cmd_i.data;
    rdata_q <= mem[AW'(raddr)];
    oob_q   <= (64'(raddr) >= STORE_DEPTH);
  end

  // Fetched samples, products and the result register.
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && q_pop_o && cmd_i.kind == CMD_PIXEL) begin
      py_q   <= cmd_i.addr_y;
      puv_q  <= cmd_i.addr_uv;
      last_q <= cmd_i.last;
    end
    if (state_q == B_RU) y_q <= rbyte;
    if (state_q == B_RV) u_q <= rbyte;
    if (state_q == B_MUL) begin
      pc_q  <= c_s * K_298;
      pre_q <= e_s * K_409;
      pgd_q <= d_s * K_100;
      pge_q <= e_s * K_208;
      pbd_q <= d_s * K_516;
    end
    if (out_load) out_q <= out_d;
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

endmodule
